// ----- hdl/cmosrtc_pkg.sv -----
// Shared types, constants and the time-field formatter for the CMOS/RTC register file.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cmosrtc_pkg;

    // Size of the byte store and the address bits it needs
    localparam int STORE_BYTES = 128;
    localparam int STORE_AW    = $clog2(STORE_BYTES);

    // Port numbers of the index/data pair
    localparam logic [7:0] PORT_INDEX = 8'h70;
    localparam logic [7:0] PORT_DATA  = 8'h71;

    // Register addresses and values with special treatment
    localparam logic [6:0] REG_SECONDS  = 7'h00;
    localparam logic [6:0] REG_ALM_SEC  = 7'h01;
    localparam logic [6:0] REG_MINUTES  = 7'h02;
    localparam logic [6:0] REG_ALM_MIN  = 7'h03;
    localparam logic [6:0] REG_HOURS    = 7'h04;
    localparam logic [6:0] REG_ALM_HR   = 7'h05;
    localparam logic [6:0] REG_WEEKDAY  = 7'h06;
    localparam logic [6:0] REG_DAY      = 7'h07;
    localparam logic [6:0] REG_MONTH    = 7'h08;
    localparam logic [6:0] REG_YEAR     = 7'h09;
    localparam logic [6:0] REG_STATUS_B = 7'h0B;
    localparam logic [6:0] REG_STATUS_D = 7'h0D;
    localparam int         STATUS_B_BINARY_BIT = 2;
    localparam logic [7:0] STATUS_D_VALUE = 8'h80;

    // Read-data source selected at decode
    localparam logic [2:0] SEL_ZERO  = 3'd0;
    localparam logic [2:0] SEL_INDEX = 3'd1;
    localparam logic [2:0] SEL_TIME  = 3'd2;
    localparam logic [2:0] SEL_STD   = 3'd3;
    localparam logic [2:0] SEL_STORE = 3'd4;

    typedef struct packed {
        logic                idx_we;
        logic                mem_we;
        logic                mem_re;
        logic [STORE_AW-1:0] mem_addr;
        logic [2:0]          sel;
        logic [6:0]          tval;
    } t_access;

    // BCD split by reciprocal multiply: v*205 >> 11 equals v/10 for v below 1029
    function automatic logic [7:0] f_time_code(input logic [6:0] v, input logic bin);
        logic [16:0] prod;
        logic [3:0]  q;
        logic [3:0]  tens;
        logic [7:0]  qx10;
        logic [7:0]  diff;
        prod = {10'd0, v} * 17'd205;
        q    = prod[14:11];
        tens = (q >= 4'd10) ? (q - 4'd10) : q;
        qx10 = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
        diff = {1'b0, v} - qx10;
        return bin ? {1'b0, v} : {tens, diff[3:0]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cmosrtc_decode.sv -----
// Access decoder: turns one bus word into store controls and a read-data source.
// Depends on cmosrtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmosrtc_decode (
    input  wire logic                 i_mode,
    input  wire logic [7:0]           i_port,
    input  wire logic [6:0]           i_index,
    input  wire logic [5:0]           i_now_seconds,
    input  wire logic [5:0]           i_now_minutes,
    input  wire logic [4:0]           i_now_hours,
    input  wire logic [2:0]           i_now_weekday,
    input  wire logic [4:0]           i_now_day,
    input  wire logic [3:0]           i_now_month,
    input  wire logic [6:0]           i_now_year,
    output cmosrtc_pkg::t_access      o_acc
);
    import cmosrtc_pkg::*;

    logic       is_idx;
    logic       mapped;
    logic [6:0] addr;
    logic       in_store;

    assign is_idx   = (i_port == PORT_INDEX);
    assign mapped   = (i_port == PORT_DATA) || i_port[7];
    assign addr     = (i_port == PORT_DATA) ? i_index : i_port[6:0];
    assign in_store = ({1'b0, addr} < 8'(STORE_BYTES));

    always_comb begin
        o_acc.idx_we   = i_mode && is_idx;
        o_acc.mem_we   = i_mode && mapped && in_store;
        o_acc.mem_re   = 1'b0;
        o_acc.mem_addr = addr[STORE_AW-1:0];
        o_acc.sel      = SEL_ZERO;
        o_acc.tval     = 7'd0;
        if (!i_mode) begin
            if (is_idx) begin
                o_acc.sel = SEL_INDEX;
            end else if (mapped) begin
                // alarm registers give the next time field
                case (addr)
                    REG_SECONDS: begin
                        o_acc.sel  = SEL_TIME;
                        o_acc.tval = {1'b0, i_now_seconds};
                    end
                    REG_ALM_SEC, REG_MINUTES: begin
                        o_acc.sel  = SEL_TIME;
                        o_acc.tval = {1'b0, i_now_minutes};
                    end
                    REG_ALM_MIN, REG_HOURS: begin
                        o_acc.sel  = SEL_TIME;
                        o_acc.tval = {2'b00, i_now_hours};
                    end
                    REG_ALM_HR, REG_WEEKDAY: begin
                        o_acc.sel  = SEL_TIME;
                        o_acc.tval = {4'd0, i_now_weekday};
                    end
                    REG_DAY: begin
                        o_acc.sel  = SEL_TIME;
                        o_acc.tval = {2'b00, i_now_day};
                    end
                    REG_MONTH: begin
                        o_acc.sel  = SEL_TIME;
                        o_acc.tval = {3'd0, i_now_month};
                    end
                    REG_YEAR: begin
                        o_acc.sel  = SEL_TIME;
                        o_acc.tval = i_now_year;
                    end
                    REG_STATUS_D: begin
                        o_acc.sel = SEL_STD;
                    end
                    default: begin
                        if (in_store) begin
                            o_acc.sel    = SEL_STORE;
                            o_acc.mem_re = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cmosrtc_store.sv -----
// Byte store: synchronous RAM with registered read, per-entry valid bits cleared at reset,
// and a shadow of the binary-mode bit of status register B. Depends on cmosrtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmosrtc_store (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_we,
    input  wire logic                         i_re,
    input  wire logic [cmosrtc_pkg::STORE_AW-1:0] i_addr,
    input  wire logic [7:0]                   i_wdata,
    output logic [7:0]                        o_rdata,
    output logic                              o_binary
);
    import cmosrtc_pkg::*;

    logic [7:0]             r_mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] r_vld;
    logic [7:0]             r_rdata;
    logic                   r_rd_vld;
    logic                   r_binary;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata  <= r_mem[i_addr];
            r_rd_vld <= r_vld[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_binary <= 1'b0;
        end else if (i_we) begin
            r_vld[i_addr] <= 1'b1;
            if (i_addr == REG_STATUS_B[STORE_AW-1:0]) begin
                r_binary <= i_wdata[STATUS_B_BINARY_BIT];
            end
        end
    end

    // entries not written since reset read as zero
    assign o_rdata  = r_rd_vld ? r_rdata : 8'h00;
    assign o_binary = r_binary;

endmodule

`default_nettype wire

// ----- hdl/cmos_rtc_register_file_unit.sv -----
// Top level of the CMOS/RTC register file: stream ports, index register, result register.
// Depends on cmosrtc_pkg, cmosrtc_decode and cmosrtc_store.
//
//  channel   direction  handshake                       payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata: access + time, tuser: mode
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata: read_data
//
// Each word gives one result word: the store is read at the accepting edge, and the
// result is then formatted into the output register once that register can load. A new
// word is taken every cycle while the output register drains, so throughput is one word
// per cycle.
// Reset clears the index, the store valid bits and the binary flag;
// there is no clearing pass. A stalled output holds the word in flight and drops tready.
`timescale 1ns / 1ps
`default_nettype none

module cmos_rtc_register_file_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] access_port, [15:8] write_data, [21:16] now_seconds, [27:22] now_minutes,
    // [32:28] now_hours, [35:33] now_weekday, [40:36] now_day, [44:41] now_month,
    // [51:45] now_year, [55:52] zero
    input  wire logic [55:0] i_s_axis_tdata,
    // [0] mode (1 = write)
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] read_data
    output logic [7:0]       o_m_axis_tdata
);
    import cmosrtc_pkg::*;

    t_access    acc;
    logic       accept;
    logic       can_load;
    logic [7:0] st_rdata;
    logic       st_binary;
    logic [7:0] result;

    logic [6:0] r_index;
    logic       r_pend;
    logic       n_pend;
    logic [2:0] r_sel;
    logic [6:0] r_tval;
    logic [6:0] r_idx_snap;
    logic       r_bin;
    logic       r_out_valid;
    logic [7:0] r_out_data;

    cmosrtc_decode u_decode (
        .i_mode        (i_s_axis_tuser),
        .i_port        (i_s_axis_tdata[7:0]),
        .i_index       (r_index),
        .i_now_seconds (i_s_axis_tdata[21:16]),
        .i_now_minutes (i_s_axis_tdata[27:22]),
        .i_now_hours   (i_s_axis_tdata[32:28]),
        .i_now_weekday (i_s_axis_tdata[35:33]),
        .i_now_day     (i_s_axis_tdata[40:36]),
        .i_now_month   (i_s_axis_tdata[44:41]),
        .i_now_year    (i_s_axis_tdata[51:45]),
        .o_acc         (acc)
    );

    cmosrtc_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (accept && acc.mem_we),
        .i_re     (accept && acc.mem_re),
        .i_addr   (acc.mem_addr),
        .i_wdata  (i_s_axis_tdata[15:8]),
        .o_rdata  (st_rdata),
        .o_binary (st_binary)
    );

    assign can_load        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_pend || can_load;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_pend = r_pend;
        if (accept) begin
            n_pend = 1'b1;
        end else if (r_pend && can_load) begin
            n_pend = 1'b0;
        end
    end

    always_comb begin
        case (r_sel)
            SEL_INDEX: result = {1'b0, r_idx_snap};
            SEL_TIME:  result = f_time_code(r_tval, r_bin);
            SEL_STD:   result = STATUS_D_VALUE;
            SEL_STORE: result = st_rdata;
            default:   result = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= 7'd0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (accept && acc.idx_we) begin
                r_index <= i_s_axis_tdata[14:8];
            end
            if (r_pend && can_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured at acceptance so a following word cannot disturb the one in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sel      <= acc.sel;
            r_tval     <= acc.tval;
            r_idx_snap <= r_index;
            r_bin      <= st_binary;
        end
        if (r_pend && can_load) begin
            r_out_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_accept_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_pend)
        else $error("accepted word not held as pending");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && r_out_valid && !i_m_axis_tready |=> r_pend && $stable(r_sel))
        else $error("pending word lost during output stall");

    a_index_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && acc.idx_we |=> r_index == $past(i_s_axis_tdata[14:8]))
        else $error("index register not updated by index write");

    a_status_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && can_load && r_sel == SEL_STD |=> o_m_axis_tvalid
            && o_m_axis_tdata == STATUS_D_VALUE)
        else $error("status register D read wrong value");
`endif

endmodule

`default_nettype wire
